@@ design/ets_pkg.sv @@
// ----------------------------------------------------------------------------
// ets_pkg
// Types, codes and character helpers for the expression token scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

    typedef enum logic [4:0] {
        K_EOF     = 5'd0,
        K_IDENT   = 5'd1,
        K_TRUE    = 5'd2,
        K_FALSE   = 5'd3,
        K_INT     = 5'd4,
        K_DOUBLE  = 5'd5,
        K_STRING  = 5'd6,
        K_LE      = 5'd7,
        K_GE      = 5'd8,
        K_EQ      = 5'd9,
        K_NE      = 5'd10,
        K_AND     = 5'd11,
        K_OR      = 5'd12,
        K_LPAREN  = 5'd13,
        K_RPAREN  = 5'd14,
        K_PLUS    = 5'd15,
        K_MINUS   = 5'd16,
        K_STAR    = 5'd17,
        K_SLASH   = 5'd18,
        K_PERCENT = 5'd19,
        K_LT      = 5'd20,
        K_GT      = 5'd21,
        K_NOT     = 5'd22
    } kind_t;

    typedef enum logic [6:0] {
        M_IDLE   = 7'b0000001,
        M_IDENT  = 7'b0000010,
        M_NUMBER = 7'b0000100,
        M_STRING = 7'b0001000,
        M_ESCAPE = 7'b0010000,
        M_DOT    = 7'b0100000,
        M_OP     = 7'b1000000
    } mode_t;

    typedef enum logic [1:0] {
        KW_NONE  = 2'd0,
        KW_TRUE  = 2'd1,
        KW_FALSE = 2'd2
    } kw_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  length;
        logic [31:0] start;
        logic        last;
    } token_t;

    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {["a":"z"]}) || (b inside {["A":"Z"]});
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
    endfunction

    function automatic logic is_op_start(input logic [7:0] b);
        return b inside {CH_LESS, CH_GREATER, CH_EQUAL, CH_BANG, CH_AMP, CH_BAR};
    endfunction

    function automatic kind_t single_kind(input logic [7:0] b);
        case (b)
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_STAR;
            "/":     return K_SLASH;
            "%":     return K_PERCENT;
            "<":     return K_LT;
            ">":     return K_GT;
            "!":     return K_NOT;
            default: return K_EOF;
        endcase
    endfunction

    function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
        kind_t k;
        k = K_EOF;
        if (b == CH_EQUAL) begin
            case (a)
                CH_LESS:    k = K_LE;
                CH_GREATER: k = K_GE;
                CH_EQUAL:   k = K_EQ;
                CH_BANG:    k = K_NE;
                default:    k = K_EOF;
            endcase
        end
        if (a == CH_AMP && b == CH_AMP) begin
            k = K_AND;
        end
        if (a == CH_BAR && b == CH_BAR) begin
            k = K_OR;
        end
        return k;
    endfunction

    function automatic logic [7:0] kw_length(input kw_t kp);
        return (kp == KW_TRUE) ? 8'd4 : 8'd5;
    endfunction

    function automatic logic [7:0] kw_char(input kw_t kp, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (kp == KW_TRUE) begin
            case (idx)
                3'd0:    c = "t";
                3'd1:    c = "r";
                3'd2:    c = "u";
                3'd3:    c = "e";
                default: c = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0:    c = "f";
                3'd1:    c = "a";
                3'd2:    c = "l";
                3'd3:    c = "s";
                3'd4:    c = "e";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic kind_t ident_kind(input kw_t kp, input logic [7:0] len);
        kind_t k;
        k = K_IDENT;
        if (kp == KW_TRUE && len == 8'd4) begin
            k = K_TRUE;
        end
        if (kp == KW_FALSE && len == 8'd5) begin
            k = K_FALSE;
        end
        return k;
    endfunction

endpackage

@@ design/expression_token_scanner.sv @@
// ----------------------------------------------------------------------------
// expression_token_scanner
// Streaming lexer: one text byte in, token kind, length and start offset out.
// ----------------------------------------------------------------------------
// Each accepted byte updates the scan state in the same cycle and pushes zero,
// one or two tokens into a four-entry result queue; the oldest queued token
// is offered. A byte is taken every cycle while the queue has room for two
// tokens, so the rate is one item per cycle as long as tokens are taken about
// as fast as they arise; an item that ends one token and makes another, or
// an end of text that flushes a pending token, adds a second queue entry and
// can hold off the input when the output side is slow.
module expression_token_scanner
    import ets_pkg::*;
#(
    parameter int unsigned MAX_LEXEME = 255
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [4:0]  token_kind,
    output logic [7:0]  token_length,
    output logic [31:0] token_start,
    output logic        last_of_run
);

    localparam logic [8:0] MaxLen = 9'(MAX_LEXEME);
    localparam logic [7:0] MaxLen8 = MaxLen[7:0];

    mode_t       mode_reg, mode_next;
    logic [7:0]  len_reg, len_next;
    kw_t         kp_reg, kp_next;
    logic        point_reg, point_next;
    logic [7:0]  pend_reg, pend_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_reg, start_next;

    token_t                 queue_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RES_PTR_W:0]     count_reg;

    logic accept, pop;

    // flush of the pending token
    logic   flush_v;
    kind_t  flush_kind;
    logic [7:0] flush_len;

    // fresh token start from the current byte
    mode_t      fresh_mode;
    logic [7:0] fresh_len;
    kw_t        fresh_kp;
    logic [7:0] fresh_pend;
    logic       fresh_emit;

    logic       a_v, b_v;
    token_t     a_tok, b_tok;
    logic       do_fresh;
    logic [8:0] grown;
    kw_t        kp_upd;
    logic       point_upd;
    kind_t      pk;

    token_t     w0_tok, w1_tok;
    logic [1:0] n_push;

    always_comb
    begin
        flush_v    = 1'b1;
        flush_kind = K_EOF;
        flush_len  = 8'd1;
        case (mode_reg)
            M_IDENT:
            begin
                flush_kind = ident_kind(kp_reg, len_reg);
                flush_len  = len_reg;
            end
            M_NUMBER:
            begin
                flush_kind = point_reg ? K_DOUBLE : K_INT;
                flush_len  = len_reg;
            end
            M_STRING, M_ESCAPE:
            begin
                flush_kind = K_STRING;
                flush_len  = len_reg;
            end
            M_DOT:
            begin
                flush_kind = K_EOF;
            end
            M_OP:
            begin
                flush_kind = single_kind(pend_reg);
            end
            default:
            begin
                flush_v = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fresh_mode = M_IDLE;
        fresh_len  = 8'd1;
        fresh_kp   = KW_NONE;
        fresh_pend = pend_reg;
        fresh_emit = 1'b0;
        if (is_space(text_byte)) begin
            fresh_len = 8'd0;
        end else if (is_alpha(text_byte) || text_byte == CH_UNDER) begin
            fresh_mode = M_IDENT;
            fresh_kp   = (text_byte == CH_T) ? KW_TRUE :
                         (text_byte == CH_F) ? KW_FALSE : KW_NONE;
        end else if (is_digit(text_byte)) begin
            fresh_mode = M_NUMBER;
        end else if (text_byte == CH_DOT) begin
            fresh_mode = M_DOT;
        end else if (text_byte == CH_QUOTE) begin
            fresh_mode = M_STRING;
        end else if (is_op_start(text_byte)) begin
            fresh_mode = M_OP;
            fresh_pend = text_byte;
        end else begin
            fresh_emit = 1'b1;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        kp_next    = kp_reg;
        point_next = point_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        pos_next   = pos_reg + 32'd1;

        a_v   = 1'b0;
        a_tok = '{kind: K_EOF, length: 8'd0, start: start_reg, last: 1'b0};
        b_v   = 1'b0;
        b_tok = '{kind: single_kind(text_byte), length: 8'd1, start: pos_reg, last: 1'b1};

        do_fresh  = 1'b0;
        grown     = {1'b0, len_reg} + 9'd1;
        kp_upd    = kp_reg;
        point_upd = point_reg | (text_byte == CH_DOT);
        pk        = pair_kind(pend_reg, text_byte);

        if (end_of_text) begin
            a_v          = flush_v;
            a_tok.kind   = flush_kind;
            a_tok.length = flush_len;
            b_v          = 1'b1;
            b_tok.kind   = K_EOF;
            b_tok.length = 8'd0;
            mode_next    = M_IDLE;
            len_next     = 8'd0;
            kp_next      = KW_NONE;
            point_next   = 1'b0;
            pend_next    = 8'd0;
            start_next   = 32'd0;
            pos_next     = 32'd0;
        end else begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_word(text_byte)) begin
                        if (kp_reg != KW_NONE &&
                            (len_reg >= kw_length(kp_reg) ||
                             kw_char(kp_reg, len_reg[2:0]) != text_byte)) begin
                            kp_upd = KW_NONE;
                        end
                        kp_next = kp_upd;
                        if (grown >= MaxLen) begin
                            len_next     = MaxLen8;
                            a_v          = 1'b1;
                            a_tok.kind   = ident_kind(kp_upd, MaxLen8);
                            a_tok.length = MaxLen8;
                            mode_next    = M_IDLE;
                        end else begin
                            len_next = grown[7:0];
                        end
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(text_byte) || text_byte == CH_DOT) begin
                        point_next = point_upd;
                        if (grown >= MaxLen) begin
                            len_next     = MaxLen8;
                            a_v          = 1'b1;
                            a_tok.kind   = point_upd ? K_DOUBLE : K_INT;
                            a_tok.length = MaxLen8;
                            mode_next    = M_IDLE;
                        end else begin
                            len_next = grown[7:0];
                        end
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (text_byte == CH_QUOTE) begin
                        len_next     = grown[7:0];
                        a_v          = 1'b1;
                        a_tok.kind   = K_STRING;
                        a_tok.length = grown[7:0];
                        mode_next    = M_IDLE;
                    end else if (text_byte == CH_BACKSLASH &&
                                 {1'b0, len_reg} < (MaxLen - 9'd1)) begin
                        len_next  = grown[7:0];
                        mode_next = M_ESCAPE;
                    end else if (grown >= MaxLen) begin
                        len_next     = MaxLen8;
                        a_v          = 1'b1;
                        a_tok.kind   = K_STRING;
                        a_tok.length = MaxLen8;
                        mode_next    = M_IDLE;
                    end else begin
                        len_next = grown[7:0];
                    end
                end
                M_ESCAPE:
                begin
                    if (grown >= MaxLen) begin
                        len_next     = MaxLen8;
                        a_v          = 1'b1;
                        a_tok.kind   = K_STRING;
                        a_tok.length = MaxLen8;
                        mode_next    = M_IDLE;
                    end else begin
                        len_next  = grown[7:0];
                        mode_next = M_STRING;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(text_byte)) begin
                        point_next = 1'b1;
                        if (MaxLen <= 9'd2) begin
                            len_next     = MaxLen8;
                            a_v          = 1'b1;
                            a_tok.kind   = K_DOUBLE;
                            a_tok.length = MaxLen8;
                            mode_next    = M_IDLE;
                        end else begin
                            len_next  = 8'd2;
                            mode_next = M_NUMBER;
                        end
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                M_OP:
                begin
                    if (pk != K_EOF) begin
                        a_v          = 1'b1;
                        a_tok.kind   = pk;
                        a_tok.length = 8'd2;
                        mode_next    = M_IDLE;
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                default:
                begin
                    do_fresh = 1'b1;
                end
            endcase

            if (do_fresh) begin
                a_v          = flush_v;
                a_tok.kind   = flush_kind;
                a_tok.length = flush_len;
                b_v          = fresh_emit;
                mode_next    = fresh_mode;
                len_next     = fresh_len;
                kp_next      = fresh_kp;
                point_next   = 1'b0;
                pend_next    = fresh_pend;
                start_next   = pos_reg;
            end
        end
    end

    // compact the two candidates into queue order
    always_comb
    begin
        w0_tok      = a_v ? a_tok : b_tok;
        w0_tok.last = !(a_v && b_v);
        w1_tok      = b_tok;
        n_push      = {1'b0, a_v} + {1'b0, b_v};
    end

    assign text_ready  = (count_reg <= (RES_PTR_W+1)'(RES_DEPTH - 2));
    assign accept      = text_valid && text_ready;
    assign token_valid = (count_reg != '0);
    assign pop         = token_valid && token_ready;

    assign token_kind   = queue_reg[rd_ptr_reg].kind;
    assign token_length = queue_reg[rd_ptr_reg].length;
    assign token_start  = queue_reg[rd_ptr_reg].start;
    assign last_of_run  = queue_reg[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            len_reg   <= 8'd0;
            kp_reg    <= KW_NONE;
            point_reg <= 1'b0;
            pend_reg  <= 8'd0;
            pos_reg   <= 32'd0;
            start_reg <= 32'd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            kp_reg    <= kp_next;
            point_reg <= point_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(n_push);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            count_reg <= count_reg + (accept ? (RES_PTR_W+1)'(n_push) : '0)
                                   - (RES_PTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && n_push != 2'd0) begin
            queue_reg[wr_ptr_reg] <= w0_tok;
            if (n_push == 2'd2) begin
                queue_reg[wr_ptr_reg + RES_PTR_W'(1)] <= w1_tok;
            end
        end
    end

endmodule
